// ----- rtl/core/lia_pkg.sv -----
// Shared types and constants for the list insert core.
// Used by lia_out_stage and list_insert_at_position_core; no dependencies.
package lia_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SEQ_W  = $clog2(2 * DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_FWD     = 2'd2,
    KIND_REV     = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SHIFT_RD = 5'b00010,
    ST_SHIFT_WR = 5'b00100,
    ST_INSERT   = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } result_t;

endpackage

// ----- rtl/core/lia_out_stage.sv -----
// Output register for result beats of the list insert core.
// Depends on lia_pkg for the result_t type.
module lia_out_stage (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load_valid,
  output logic                                  load_ready,
  input  lia_pkg::result_t                      load_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lia_pkg::kind_t                        kind,
  output logic signed [lia_pkg::DATA_W-1:0]     element,
  output logic                                  last
);

  lia_pkg::result_t held;
  logic             valid;

  // The register can take a new beat when empty or when its beat leaves now.
  assign load_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      held <= load_data;
    end
  end

  assign out_valid = valid;
  assign kind      = held.kind;
  assign element   = held.element;
  assign last      = held.last;

endmodule

// ----- rtl/core/list_insert_at_position_core.sv -----
// Top level of the list insert core: sequencer, element memory and count.
// Depends on lia_pkg and lia_out_stage.
//
// Usage: an input beat (position, new_value) is taken on in_valid and
// in_ready. A position above the current count yields one beat of kind
// invalid; a full list yields one beat of kind full. Otherwise the value is
// inserted and the whole list goes out front to back (kind forward), then
// back to front (kind reverse), with last set on the final beat.
// Sequence: the insert moves the entries at and behind the position one place
// back, one read and then one write per moved entry through the memory's
// separate read and write ports, then ends the shift and writes the new value.
// Streaming then gives one beat per cycle while out_ready stays high, 2*n
// beats for a list of n entries, and then the final beat is loaded. The block
// takes the next input once it is idle again with no beat pending.
// Reset clears the state, the count and the valid flags; the memory holds
// garbage that is never read. When the receiver stalls, the output register
// and one memory read in flight hold their data and the sequencer waits.
module list_insert_at_position_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lia_pkg::POS_W-1:0]             position,
  input  logic signed [lia_pkg::DATA_W-1:0]     new_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lia_pkg::kind_t                        kind,
  output logic signed [lia_pkg::DATA_W-1:0]     element,
  output logic                                  last
);

  lia_pkg::state_t             state, state_next;
  logic [lia_pkg::CNT_W-1:0]   count, count_next;
  logic [lia_pkg::CNT_W-1:0]   k, k_next;
  logic [lia_pkg::ADDR_W-1:0]  pos, pos_next;
  logic [lia_pkg::DATA_W-1:0]  val, val_next;
  logic [lia_pkg::SEQ_W-1:0]   seq, seq_next;
  logic [lia_pkg::SEQ_W-1:0]   total, total_next;
  logic                        have_data, have_data_next;
  lia_pkg::kind_t              rd_kind, rd_kind_next;
  logic                        rd_last, rd_last_next;
  logic                        rd_zero, rd_zero_next;

  logic [lia_pkg::DATA_W-1:0]  mem [lia_pkg::DEPTH];
  logic [lia_pkg::DATA_W-1:0]  mem_q;
  logic                        rd_en, wr_en;
  logic [lia_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
  logic [lia_pkg::DATA_W-1:0]  wr_data;

  logic                        load_ready, load;
  logic                        issue;
  logic [lia_pkg::SEQ_W-1:0]   rev_idx;
  lia_pkg::result_t            load_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign in_ready = (state == lia_pkg::ST_IDLE) && !have_data;
  assign load     = have_data && load_ready;
  assign issue    = (state == lia_pkg::ST_EMIT) && (seq != total) && (!have_data || load);
  assign rev_idx  = total - seq - lia_pkg::SEQ_W'(1);

  assign load_data.kind    = rd_kind;
  assign load_data.element = rd_zero ? '0 : $signed(mem_q);
  assign load_data.last    = rd_last;

  always_comb begin
    state_next     = state;
    count_next     = count;
    k_next         = k;
    pos_next       = pos;
    val_next       = val;
    seq_next       = seq;
    total_next     = total;
    have_data_next = have_data;
    rd_kind_next   = rd_kind;
    rd_last_next   = rd_last;
    rd_zero_next   = rd_zero;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    rd_addr        = '0;
    wr_addr        = '0;
    wr_data        = val;

    case (state)
      lia_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          pos_next   = position[lia_pkg::ADDR_W-1:0];
          val_next   = new_value;
          k_next     = count;
          seq_next   = '0;
          total_next = '0;
          if (position > lia_pkg::POS_W'(count)) begin
            have_data_next = 1'b1;
            rd_kind_next   = lia_pkg::KIND_INVALID;
            rd_last_next   = 1'b1;
            rd_zero_next   = 1'b1;
            state_next     = lia_pkg::ST_EMIT;
          end else if (count == lia_pkg::CNT_W'(lia_pkg::DEPTH)) begin
            have_data_next = 1'b1;
            rd_kind_next   = lia_pkg::KIND_FULL;
            rd_last_next   = 1'b1;
            rd_zero_next   = 1'b1;
            state_next     = lia_pkg::ST_EMIT;
          end else begin
            state_next = lia_pkg::ST_SHIFT_RD;
          end
        end
      end
      lia_pkg::ST_SHIFT_RD: begin
        if (k > {1'b0, pos}) begin
          rd_en      = 1'b1;
          rd_addr    = lia_pkg::ADDR_W'(k - lia_pkg::CNT_W'(1));
          state_next = lia_pkg::ST_SHIFT_WR;
        end else begin
          state_next = lia_pkg::ST_INSERT;
        end
      end
      lia_pkg::ST_SHIFT_WR: begin
        wr_en      = 1'b1;
        wr_addr    = k[lia_pkg::ADDR_W-1:0];
        wr_data    = mem_q;
        k_next     = k - lia_pkg::CNT_W'(1);
        state_next = lia_pkg::ST_SHIFT_RD;
      end
      lia_pkg::ST_INSERT: begin
        wr_en      = 1'b1;
        wr_addr    = pos;
        wr_data    = val;
        count_next = count + lia_pkg::CNT_W'(1);
        seq_next   = '0;
        total_next = {lia_pkg::SEQ_W'(count) + lia_pkg::SEQ_W'(1)} << 1;
        state_next = lia_pkg::ST_EMIT;
      end
      lia_pkg::ST_EMIT: begin
        // The read register holds its data until the next read, so one
        // beat can be loaded and the following element read in the same cycle.
        if (issue) begin
          rd_en          = 1'b1;
          have_data_next = 1'b1;
          rd_zero_next   = 1'b0;
          seq_next       = seq + lia_pkg::SEQ_W'(1);
          rd_last_next   = (seq + lia_pkg::SEQ_W'(1)) == total;
          if (seq < lia_pkg::SEQ_W'(count)) begin
            rd_addr      = seq[lia_pkg::ADDR_W-1:0];
            rd_kind_next = lia_pkg::KIND_FWD;
          end else begin
            rd_addr      = rev_idx[lia_pkg::ADDR_W-1:0];
            rd_kind_next = lia_pkg::KIND_REV;
          end
        end else if (load) begin
          have_data_next = 1'b0;
        end
        if (load && rd_last) begin
          state_next = lia_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next     = lia_pkg::ST_IDLE;
        have_data_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lia_pkg::ST_IDLE;
      count     <= '0;
      have_data <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      have_data <= have_data_next;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    pos     <= pos_next;
    val     <= val_next;
    seq     <= seq_next;
    total   <= total_next;
    rd_kind <= rd_kind_next;
    rd_last <= rd_last_next;
    rd_zero <= rd_zero_next;
  end

  lia_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (have_data),
    .load_ready (load_ready),
    .load_data  (load_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .element    (element),
    .last       (last)
  );

endmodule
